@@ hw/rtl/btnf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the button filter and key queue.
package btnf_pkg;

    localparam int CODE_W    = 8;
    localparam int PIN_COUNT = 5;
    localparam int SLOT_MAX  = 8;
    localparam int CODE_REGS = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_UP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DOWN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_CONFIRM = 3'd5;

    localparam logic [CODE_W-1:0] FILTER_RESET = 8'd5;
    localparam logic [CODE_W-1:0] CODE_UP_RESET      = 8'd1;
    localparam logic [CODE_W-1:0] CODE_DOWN_RESET    = 8'd2;
    localparam logic [CODE_W-1:0] CODE_LEFT_RESET    = 8'd3;
    localparam logic [CODE_W-1:0] CODE_RIGHT_RESET   = 8'd4;
    localparam logic [CODE_W-1:0] CODE_CONFIRM_RESET = 8'd5;

    // Codes to be queued by one scan tick, in button order
    typedef struct packed {
        logic [SLOT_MAX-1:0]             push;
        logic [SLOT_MAX-1:0][CODE_W-1:0] code;
    } push_t;

    // One read answer
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] key_code;
        logic              queue_empty;
    } result_t;

endpackage

@@ hw/rtl/button_filter_key_fifo.sv @@
`timescale 1ns / 1ps
// Button debounce filter with key code ring: one word accepted per cycle, scan or read,
// while the skid stage is free. A read word's answer is registered towards the output.
// A scan tick advances the counter of each pressed button and queues up to
// BUTTON_COUNT codes in that same cycle. Scan words give no output word.
// Reset (rst_n low, asynchronous): counters and ring pointers clear, registers take
// their default codes; ring contents are not cleared.
module button_filter_key_fifo #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int BUTTON_COUNT = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [4:0] pin_levels, [7:5] zero
    input  logic [0:0]                        s_tuser,   // [0] req_type
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] key_code
    output logic [0:0]                        m_tuser,   // [0] queue_empty
    // Configuration writes
    input  logic                              cfg_we,
    input  logic [btnf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [btnf_pkg::CODE_W-1:0]       cfg_data
);
    import btnf_pkg::*;

    logic    accept;
    logic    scan_en;
    logic    rd_en;
    logic    room;
    push_t   push;
    result_t result;

    // Take a word whenever the skid stage is free, even with a result waiting
    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;
    assign scan_en  = accept && !s_tuser[0];
    assign rd_en    = accept && s_tuser[0];

    // Advance counters and pick the codes to queue for this tick
    btnf_scan #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan_en   (scan_en),
        .pins      (s_tdata[PIN_COUNT-1:0]),
        .push      (push)
    );

    // Write queued codes, pop the oldest on a read
    btnf_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .rd_en  (rd_en),
        .result (result)
    );

    // Hold answers until the output side takes them
    btnf_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (m_tdata),
        .out_empty (m_tuser[0])
    );

`ifndef NO_ASSERTIONS
    // Input stalls only while an answer is parked on the output
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output word pending");

    // A read into an idle output shows an answer next cycle
    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] && !m_tvalid) |=> m_tvalid)
        else $error("read word produced no answer");

    // A scan tick into an idle output gives no answer
    a_scan_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0] && !m_tvalid) |=> !m_tvalid)
        else $error("scan word produced an answer");

    // An empty answer carries code zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("empty answer with nonzero key code");
`endif

endmodule

@@ hw/rtl/btnf_scan.sv @@
`timescale 1ns / 1ps
// Configuration registers, per-button press counters and queue push generation.
module btnf_scan #(
    parameter int BUTTON_COUNT = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [btnf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [btnf_pkg::CODE_W-1:0]       cfg_data,
    input  logic                              scan_en,
    input  logic [btnf_pkg::PIN_COUNT-1:0]    pins,
    output btnf_pkg::push_t                   push
);
    import btnf_pkg::*;

    logic [CODE_W-1:0]                 filter_reg;
    logic [CODE_REGS-1:0][CODE_W-1:0]  code_reg;
    logic [BUTTON_COUNT-1:0][CODE_W-1:0] count_reg;
    logic [BUTTON_COUNT-1:0][CODE_W-1:0] count_next;
    logic [SLOT_MAX-1:0]               pins_ext;
    logic [SLOT_MAX-1:0][CODE_W-1:0]   code_ext;

    // Buttons without a pin read as released, slots without a register as disabled
    assign pins_ext = {{(SLOT_MAX-PIN_COUNT){1'b1}}, pins};

    always_comb
    begin
        code_ext = '0;
        for (int i = 0; i < CODE_REGS; i++)
        begin
            code_ext[i] = code_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg  <= FILTER_RESET;
            code_reg[0] <= CODE_UP_RESET;
            code_reg[1] <= CODE_DOWN_RESET;
            code_reg[2] <= CODE_LEFT_RESET;
            code_reg[3] <= CODE_RIGHT_RESET;
            code_reg[4] <= CODE_CONFIRM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_TICKS: filter_reg  <= cfg_data;
                CFG_CODE_UP:      code_reg[0] <= cfg_data;
                CFG_CODE_DOWN:    code_reg[1] <= cfg_data;
                CFG_CODE_LEFT:    code_reg[2] <= cfg_data;
                CFG_CODE_RIGHT:   code_reg[3] <= cfg_data;
                CFG_CODE_CONFIRM: code_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Count presses below the filter time, else clear and queue a nonzero code
    always_comb
    begin
        count_next = count_reg;
        push       = '0;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            push.code[i] = code_ext[i];
            if (scan_en && !pins_ext[i])
            begin
                if (count_reg[i] < filter_reg)
                begin
                    count_next[i] = count_reg[i] + 1'b1;
                end
                else
                begin
                    count_next[i] = '0;
                    push.push[i]  = (code_ext[i] != '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/btnf_ring.sv @@
`timescale 1ns / 1ps
// Key code ring: several writes per scan tick, one read per request.
module btnf_ring #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  btnf_pkg::push_t   push,
    input  logic              rd_en,
    output btnf_pkg::result_t result
);
    import btnf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [QUEUE_DEPTH-1:0][CODE_W-1:0] store_reg;
    logic [QUEUE_DEPTH-1:0][CODE_W-1:0] store_next;
    logic [PTR_W-1:0] write_ptr_reg;
    logic [PTR_W-1:0] write_ptr_next;
    logic [PTR_W-1:0] read_ptr_reg;
    logic [PTR_W-1:0] read_ptr_next;
    logic             empty;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    // Queue codes in button order; a later write to the same slot wins
    always_comb
    begin
        store_next     = store_reg;
        write_ptr_next = write_ptr_reg;
        for (int i = 0; i < SLOT_MAX; i++)
        begin
            if (push.push[i])
            begin
                store_next[write_ptr_next] = push.code[i];
                write_ptr_next             = ring_next(write_ptr_next);
            end
        end
    end

    assign empty = (read_ptr_reg == write_ptr_reg);

    always_comb
    begin
        read_ptr_next      = read_ptr_reg;
        result.valid       = rd_en;
        result.queue_empty = empty;
        result.key_code    = empty ? '0 : store_reg[read_ptr_reg];
        if (rd_en && !empty)
        begin
            read_ptr_next = ring_next(read_ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg <= '0;
            read_ptr_reg  <= '0;
        end
        else
        begin
            write_ptr_reg <= write_ptr_next;
            read_ptr_reg  <= read_ptr_next;
        end
    end

endmodule

@@ hw/rtl/btnf_obuf.sv @@
`timescale 1ns / 1ps
// Result register with a skid stage towards the output stream.
module btnf_obuf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  btnf_pkg::result_t             result,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [btnf_pkg::CODE_W-1:0]   out_code,
    output logic                          out_empty
);
    import btnf_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_empty_reg, out_empty_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [CODE_W-1:0] skid_code_reg, skid_code_next;
    logic              skid_empty_reg, skid_empty_next;
    logic              pop;

    assign pop  = out_valid_reg && out_ready;
    assign room = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_empty_next  = out_empty_reg;
        skid_valid_next = skid_valid_reg;
        skid_code_next  = skid_code_reg;
        skid_empty_next = skid_empty_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_code_next   = skid_code_reg;
                out_empty_next  = skid_empty_reg;
                skid_valid_next = result.valid;
                skid_code_next  = result.key_code;
                skid_empty_next = result.queue_empty;
            end
            else
            begin
                out_valid_next = result.valid;
                out_code_next  = result.key_code;
                out_empty_next = result.queue_empty;
            end
        end
        else if (result.valid)
        begin
            skid_valid_next = 1'b1;
            skid_code_next  = result.key_code;
            skid_empty_next = result.queue_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg   <= out_code_next;
        out_empty_reg  <= out_empty_next;
        skid_code_reg  <= skid_code_next;
        skid_empty_reg <= skid_empty_next;
    end

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_empty = out_empty_reg;

endmodule
